// ----- src/bba_pkg.sv -----
// Shared types and codes for the bitmap block allocator.
// No dependencies; used by bitmap_block_allocator_unit.

package bba_pkg;

	localparam int OPCODE_W = 1;
	localparam int SIZE_W   = 13;
	localparam int INDEX_W  = 8;
	localparam int STATUS_W = 2;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [OPCODE_W-1:0] opcode_t;

	localparam opcode_t OP_ALLOC = 1'b0;
	localparam opcode_t OP_FREE  = 1'b1;

	localparam status_t STAT_OK        = 2'd0;
	localparam status_t STAT_NO_RUN    = 2'd1;
	localparam status_t STAT_BAD_INDEX = 2'd2;
	localparam status_t STAT_BAD_SIZE  = 2'd3;

	// Largest size that the 13-bit size field can carry.
	localparam int SIZE_FIELD_MAX = (1 << SIZE_W) - 1;

endpackage

// ----- src/bba_div.sv -----
// Constant divider by reciprocal multiplication: registers floor(dividend / DIVISOR).
// Stand-alone; instantiated by bitmap_block_allocator_unit.

module bba_div #(
	parameter int DIVIDEND_W = 14,
	parameter int DIVISOR    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	// Reciprocal rounded up with a shift of DIVIDEND_W + ceil(log2 DIVISOR): the error stays
	// below one quotient step for every dividend under 2**DIVIDEND_W.
	localparam int     SHIFT     = DIVIDEND_W + $clog2(DIVISOR);
	localparam int     RECIP_W   = DIVIDEND_W + 2;
	localparam int     PROD_W    = DIVIDEND_W + RECIP_W;
	localparam longint RECIP_VAL = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) /
	                               longint'(DIVISOR);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

	logic                  done_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [PROD_W-1:0]     product;

	assign product = PROD_W'(dividend) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= DIVIDEND_W'(product >> SHIFT);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/bitmap_block_allocator_unit.sv -----
// First-fit bitmap block allocator: top level, sequencer and used-bit memory.
// Depends on bba_pkg and bba_div.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | into unit | in_valid/in_stall  | opcode, size_bytes, block_index
//  out     | from unit | out_valid/out_stall| status, start_block, map_empty
//
// After reset all BLOCK_COUNT blocks of the used map are cleared, one block a cycle,
// with in_stall high. One transaction at a time: the block count comes from one
// reciprocal multiply. An allocate then scans the map one block a cycle through the
// memory read port and writes the run one block a cycle; a free reads and clears one
// block a cycle and drains one more. Bad size or index skips the work. The result
// waits in an output register while out_stall is high, and a new transaction is
// taken meanwhile.

module bitmap_block_allocator_unit #(
	parameter int BLOCK_COUNT  = 256,
	parameter int BLOCK_BYTES  = 16,
	parameter int HEADER_BYTES = 16,
	parameter int MAX_BYTES    = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bba_pkg::OPCODE_W-1:0]  opcode,
	input  logic [bba_pkg::SIZE_W-1:0]    size_bytes,
	input  logic [bba_pkg::INDEX_W-1:0]   block_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bba_pkg::STATUS_W-1:0]  status,
	output logic [bba_pkg::INDEX_W-1:0]   start_block,
	output logic                          map_empty
);

	localparam int IDX_W    = $clog2(BLOCK_COUNT);
	localparam int CNT_W    = $clog2(BLOCK_COUNT + 1);
	localparam int SIZE_TOP = (MAX_BYTES < bba_pkg::SIZE_FIELD_MAX) ?
	                          MAX_BYTES : bba_pkg::SIZE_FIELD_MAX;
	localparam int TOT_MAX  = SIZE_TOP + HEADER_BYTES + BLOCK_BYTES - 1;
	localparam int TOT_W    = $clog2(TOT_MAX + 1);
	localparam int LEN_W    = TOT_W;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_MARK  = 3'd4;
	localparam logic [2:0] S_FREE  = 3'd5;
	localparam logic [2:0] S_DRAIN = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	localparam logic [CNT_W-1:0] ADDR_END  = CNT_W'(BLOCK_COUNT);
	localparam logic [CNT_W-1:0] ADDR_LAST = CNT_W'(BLOCK_COUNT - 1);

	logic [2:0]               state_q;
	bba_pkg::opcode_t         op_q;
	bba_pkg::status_t         status_q;
	logic [LEN_W-1:0]         len_q;
	logic [CNT_W-1:0]         addr_q;
	logic [LEN_W-1:0]         left_q;
	logic [LEN_W-1:0]         run_q;
	logic [CNT_W-1:0]         first_q;
	logic [CNT_W-1:0]         used_cnt_q;
	logic [bba_pkg::INDEX_W-1:0] block_index_q;

	logic                     rd_valid_s1;
	logic [CNT_W-1:0]         rd_addr_s1;
	logic                     rd_bit_s1;

	logic                     map_q [BLOCK_COUNT];

	logic                     out_valid_q;
	bba_pkg::status_t         out_status_q;
	logic [bba_pkg::INDEX_W-1:0] out_start_q;
	logic                     out_empty_q;

	logic                     accept;
	logic                     size_bad;
	logic                     index_bad;
	logic                     div_start;
	logic [TOT_W-1:0]         dividend;
	logic                     div_done;
	logic [TOT_W-1:0]         quotient;

	logic                     mem_we;
	logic                     mem_wbit;
	logic                     rd_issue;
	logic [LEN_W:0]           run_next;
	logic                     run_found;
	logic [CNT_W-1:0]         run_start;
	logic                     out_free;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE;
	assign size_bad  = (size_bytes == '0) || (32'(size_bytes) > 32'(MAX_BYTES));
	assign index_bad = (opcode == bba_pkg::OP_FREE) &&
	                   (32'(block_index) >= 32'(BLOCK_COUNT));
	assign div_start = accept && !size_bad && !index_bad;
	assign dividend  = TOT_W'(size_bytes) + TOT_W'(HEADER_BYTES + BLOCK_BYTES - 1);
	assign out_free  = !out_valid_q || !out_stall;

	bba_div #(
		.DIVIDEND_W(TOT_W),
		.DIVISOR   (BLOCK_BYTES)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.done    (div_done),
		.quotient(quotient)
	);

	// Run tracking on the block returned by the read port.
	always_comb begin
		run_next  = {1'b0, run_q} + 1'b1;
		run_found = (state_q == S_SCAN) && rd_valid_s1 && !rd_bit_s1 &&
		            (run_next >= {1'b0, len_q});
		run_start = (run_q == '0) ? rd_addr_s1 : first_q;
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_wbit = 1'b0;
		rd_issue = 1'b0;
		unique case (state_q)
			S_CLEAR: mem_we = 1'b1;
			S_SCAN:  rd_issue = addr_q != ADDR_END;
			S_MARK: begin
				mem_we   = 1'b1;
				mem_wbit = 1'b1;
			end
			S_FREE: begin
				mem_we   = 1'b1;
				rd_issue = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Used-bit memory: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_q[addr_q[IDX_W-1:0]] <= mem_wbit;
		end
		rd_bit_s1  <= map_q[addr_q[IDX_W-1:0]];
		rd_addr_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			used_cnt_q  <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_issue;
			// Count down for every used block that a free clears.
			if ((state_q == S_FREE || state_q == S_DRAIN) && rd_valid_s1 && rd_bit_s1) begin
				used_cnt_q <= used_cnt_q - 1'b1;
			end
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == ADDR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= div_start ? S_DIV : S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (op_q == bba_pkg::OP_ALLOC) begin
							state_q <= S_SCAN;
							addr_q  <= '0;
						end else begin
							state_q <= S_FREE;
							addr_q  <= CNT_W'(block_index_q);
						end
					end
				end
				S_SCAN: begin
					if (run_found) begin
						state_q    <= S_MARK;
						addr_q     <= run_start;
						used_cnt_q <= used_cnt_q + CNT_W'(len_q);
					end else begin
						if (rd_issue) begin
							addr_q <= addr_q + 1'b1;
						end
						if (rd_valid_s1 && rd_addr_s1 == ADDR_LAST) begin
							state_q <= S_DONE;
						end
					end
				end
				S_MARK: begin
					addr_q <= addr_q + 1'b1;
					if (left_q == LEN_W'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_FREE: begin
					addr_q <= addr_q + 1'b1;
					// Stop at the end of the run or at the last block of the pool.
					if (left_q == LEN_W'(1) || addr_q == ADDR_LAST) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Transaction payload and work registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q          <= opcode;
			block_index_q <= block_index;
			priority if (size_bad) begin
				status_q <= bba_pkg::STAT_BAD_SIZE;
			end else if (index_bad) begin
				status_q <= bba_pkg::STAT_BAD_INDEX;
			end else begin
				status_q <= bba_pkg::STAT_OK;
			end
		end
		if (state_q == S_DIV && div_done) begin
			len_q  <= quotient;
			left_q <= quotient;
			run_q  <= '0;
		end
		if (state_q == S_SCAN && rd_valid_s1) begin
			if (rd_bit_s1) begin
				run_q <= '0;
			end else begin
				run_q <= run_next[LEN_W-1:0];
				if (run_q == '0) begin
					first_q <= rd_addr_s1;
				end
			end
			if (run_found) begin
				left_q  <= len_q;
			end else if (rd_addr_s1 == ADDR_LAST) begin
				status_q <= bba_pkg::STAT_NO_RUN;
			end
		end
		if (state_q == S_MARK || state_q == S_FREE) begin
			left_q <= left_q - 1'b1;
		end
	end

	// Result register: holds while out_stall is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= status_q;
			out_start_q  <= (status_q == bba_pkg::STAT_OK && op_q == bba_pkg::OP_ALLOC) ?
			                bba_pkg::INDEX_W'(first_q) : '0;
			out_empty_q  <= used_cnt_q == '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign start_block = out_start_q;
	assign map_empty   = out_empty_q;

endmodule
